### sv/itoaf_pkg.sv
// Shared definitions for the integer to ASCII formatter: character codes,
// format kinds and the read-only control program of the sequencer.
// Depends on nothing; used by integer_to_ascii_formatter_unit.
package itoaf_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int STEP_W            = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [1:0] KIND_SDEC = 2'd0;
   localparam logic [1:0] KIND_UDEC = 2'd1;
   localparam logic [1:0] KIND_BIN  = 2'd2;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_WAIT      = 4'd0;
   localparam step_type STEP_KIND_CHK  = 4'd1;
   localparam step_type STEP_BIN_CHK   = 4'd2;
   localparam step_type STEP_SIGN_CHK  = 4'd3;
   localparam step_type STEP_MINUS     = 4'd4;
   localparam step_type STEP_DABBLE    = 4'd5;
   localparam step_type STEP_DIG_INIT  = 4'd6;
   localparam step_type STEP_DIG_LEAD  = 4'd7;
   localparam step_type STEP_DIG_SKIP  = 4'd8;
   localparam step_type STEP_DIG_EMIT  = 4'd9;
   localparam step_type STEP_DIG_DONE  = 4'd10;
   localparam step_type STEP_BIN_INIT  = 4'd11;
   localparam step_type STEP_BIN_LEAD  = 4'd12;
   localparam step_type STEP_BIN_SKIP  = 4'd13;
   localparam step_type STEP_BIN_EMIT  = 4'd14;
   localparam step_type STEP_BIN_DONE  = 4'd15;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_EMIT_MINUS,
      OP_DABBLE,
      OP_DIG_INIT,
      OP_SHIFT_DIG,
      OP_EMIT_DIG,
      OP_BIN_INIT,
      OP_SHIFT_BIT,
      OP_EMIT_BIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_ACCEPT,
      COND_KIND_BAD,
      COND_KIND_BIN,
      COND_NOT_NEG,
      COND_CNT_NZ,
      COND_LEAD_DONE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type cw;
      case (step)
         STEP_WAIT:     cw = '{op: OP_LOAD,       cond: COND_NO_ACCEPT, target: STEP_WAIT};
         STEP_KIND_CHK: cw = '{op: OP_NONE,       cond: COND_KIND_BAD,  target: STEP_WAIT};
         STEP_BIN_CHK:  cw = '{op: OP_NONE,       cond: COND_KIND_BIN,  target: STEP_BIN_INIT};
         STEP_SIGN_CHK: cw = '{op: OP_NONE,       cond: COND_NOT_NEG,   target: STEP_DABBLE};
         STEP_MINUS:    cw = '{op: OP_EMIT_MINUS, cond: COND_NEVER,     target: STEP_WAIT};
         STEP_DABBLE:   cw = '{op: OP_DABBLE,     cond: COND_CNT_NZ,    target: STEP_DABBLE};
         STEP_DIG_INIT: cw = '{op: OP_DIG_INIT,   cond: COND_NEVER,     target: STEP_WAIT};
         STEP_DIG_LEAD: cw = '{op: OP_NONE,       cond: COND_LEAD_DONE, target: STEP_DIG_EMIT};
         STEP_DIG_SKIP: cw = '{op: OP_SHIFT_DIG,  cond: COND_ALWAYS,    target: STEP_DIG_LEAD};
         STEP_DIG_EMIT: cw = '{op: OP_EMIT_DIG,   cond: COND_CNT_NZ,    target: STEP_DIG_EMIT};
         STEP_DIG_DONE: cw = '{op: OP_NONE,       cond: COND_ALWAYS,    target: STEP_WAIT};
         STEP_BIN_INIT: cw = '{op: OP_BIN_INIT,   cond: COND_NEVER,     target: STEP_WAIT};
         STEP_BIN_LEAD: cw = '{op: OP_NONE,       cond: COND_LEAD_DONE, target: STEP_BIN_EMIT};
         STEP_BIN_SKIP: cw = '{op: OP_SHIFT_BIT,  cond: COND_ALWAYS,    target: STEP_BIN_LEAD};
         STEP_BIN_EMIT: cw = '{op: OP_EMIT_BIT,   cond: COND_CNT_NZ,    target: STEP_BIN_EMIT};
         STEP_BIN_DONE: cw = '{op: OP_NONE,       cond: COND_ALWAYS,    target: STEP_WAIT};
         default:       cw = '{op: OP_NONE,       cond: COND_ALWAYS,    target: STEP_WAIT};
      endcase
      return cw;
   endfunction

endpackage

### sv/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter: a microcoded sequencer over a BCD and shift datapath.
// Depends on itoaf_pkg for character codes, format kinds and the control program.
// After acceptance a binary item skips its leading zero bits before its first character; a
// decimal item emits a minus sign if negative, converts the magnitude by double dabble and
// skips its leading zero digits. The digits then follow one character a cycle while the
// receiver does not stall. One item at a time; reset returns the sequencer to its wait step.
module integer_to_ascii_formatter_unit #(
   parameter int WORD_BITS = itoaf_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [WORD_BITS-1:0] req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_ch,
   output logic                 rsp_last
);

   localparam int NDIG  = (WORD_BITS * 301) / 1000 + 1;
   localparam int BCD_W = 4 * NDIG;
   localparam int CNT_W = $clog2(WORD_BITS);

   itoaf_pkg::step_type      pc_ff, pc_in;
   itoaf_pkg::ctrl_word_type cw;
   logic [1:0]               kind_ff, kind_in;
   logic                     neg_ff, neg_in;
   logic [WORD_BITS-1:0]     mag_ff, mag_in;
   logic [BCD_W-1:0]         bcd_ff, bcd_in, bcd_adj;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_ch_ff, rsp_ch_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     accept, out_free, is_emit, hold, cond_true;
   logic [3:0]               top_dig;
   logic                     lead_done;

   assign cw        = itoaf_pkg::ucode(pc_ff);
   assign req_stall = (cw.op != itoaf_pkg::OP_LOAD);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_emit   = (cw.op inside {itoaf_pkg::OP_EMIT_MINUS, itoaf_pkg::OP_EMIT_DIG,
                                     itoaf_pkg::OP_EMIT_BIT});
   assign hold      = is_emit && !out_free;
   assign top_dig   = bcd_ff[BCD_W-1 -: 4];

   always_comb begin
      if (pc_ff == itoaf_pkg::STEP_BIN_LEAD) begin
         lead_done = mag_ff[WORD_BITS-1] || (cnt_ff == '0);
      end else begin
         lead_done = (top_dig != 4'd0) || (cnt_ff == '0);
      end
   end

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      case (cw.cond)
         itoaf_pkg::COND_NEVER:     cond_true = 1'b0;
         itoaf_pkg::COND_ALWAYS:    cond_true = 1'b1;
         itoaf_pkg::COND_NO_ACCEPT: cond_true = !accept;
         itoaf_pkg::COND_KIND_BAD:  cond_true = !(kind_ff inside {itoaf_pkg::KIND_SDEC,
                                                   itoaf_pkg::KIND_UDEC, itoaf_pkg::KIND_BIN});
         itoaf_pkg::COND_KIND_BIN:  cond_true = (kind_ff == itoaf_pkg::KIND_BIN);
         itoaf_pkg::COND_NOT_NEG:   cond_true = !neg_ff;
         itoaf_pkg::COND_CNT_NZ:    cond_true = (cnt_ff != '0);
         itoaf_pkg::COND_LEAD_DONE: cond_true = lead_done;
         default:                   cond_true = 1'b0;
      endcase
   end

   always_comb begin
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (hold) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = cw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
      if (!hold) begin
         case (cw.op)
            itoaf_pkg::OP_LOAD: begin
               if (accept) begin
                  kind_in = req_kind;
                  neg_in  = (req_kind == itoaf_pkg::KIND_SDEC) && req_value[WORD_BITS-1];
                  mag_in  = neg_in ? (~req_value + 1'b1) : req_value;
                  bcd_in  = '0;
                  cnt_in  = CNT_W'(WORD_BITS - 1);
               end
            end
            itoaf_pkg::OP_EMIT_MINUS: begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = itoaf_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
            end
            itoaf_pkg::OP_DABBLE: begin
               bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[WORD_BITS-1]};
               mag_in = {mag_ff[WORD_BITS-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
            end
            itoaf_pkg::OP_DIG_INIT: begin
               cnt_in = CNT_W'(NDIG - 1);
            end
            itoaf_pkg::OP_SHIFT_DIG: begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end
            itoaf_pkg::OP_EMIT_DIG: begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = itoaf_pkg::CHAR_ZERO + {4'd0, top_dig};
               rsp_last_in  = (cnt_ff == '0);
               bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
               cnt_in       = cnt_ff - 1'b1;
            end
            itoaf_pkg::OP_BIN_INIT: begin
               cnt_in = CNT_W'(WORD_BITS - 1);
            end
            itoaf_pkg::OP_SHIFT_BIT: begin
               mag_in = {mag_ff[WORD_BITS-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
            end
            itoaf_pkg::OP_EMIT_BIT: begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = itoaf_pkg::CHAR_ZERO + {7'd0, mag_ff[WORD_BITS-1]};
               rsp_last_in  = (cnt_ff == '0);
               mag_in       = {mag_ff[WORD_BITS-2:0], 1'b0};
               cnt_in       = cnt_ff - 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= itoaf_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ch    = rsp_ch_ff;
   assign rsp_last  = rsp_last_ff;

   // A character that is not the last one means the sequencer is still busy with its item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (pc_ff != itoaf_pkg::STEP_WAIT))
      else $error("non-final character pending while sequencer waits for an item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ch_ff >= itoaf_pkg::CHAR_ZERO && rsp_ch_ff <= itoaf_pkg::CHAR_NINE)
                        || rsp_ch_ff == itoaf_pkg::CHAR_MINUS))
      else $error("result character is neither a digit nor a minus sign");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ch_ff == itoaf_pkg::CHAR_MINUS) |-> !rsp_last_ff)
      else $error("minus sign marked as final character");

   assert property (@(posedge clock) disable iff (reset)
      hold |=> ($stable(pc_ff) && $stable(cnt_ff)))
      else $error("sequencer advanced while the result register was blocked");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (pc_ff == itoaf_pkg::STEP_KIND_CHK))
      else $error("accepted item did not start the control program");

endmodule

### dv/tb_integer_to_ascii_formatter_unit.sv
// Self-checking testbench for integer_to_ascii_formatter_unit: directed table, random items,
// random idling on both channels and one long receiver hold-off, checked against a predictor.
// Depends on itoaf_pkg and the formatter RTL only.
module tb_integer_to_ascii_formatter_unit;

   localparam int WORD_BITS = itoaf_pkg::WORD_BITS_DEFAULT;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 128;
   localparam int QUIET_FROM = 96;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_CHARS = 150;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   typedef struct {
      logic [1:0]           kind;
      logic [WORD_BITS-1:0] value;
      bit                   typed;
      string                text;
   } directed_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_kind = itoaf_pkg::KIND_SDEC;
   logic [WORD_BITS-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_ch;
   logic                 rsp_last;

   text_char_type pending_text [$];
   int errors = 0;
   int chars_seen = 0;
   int cycle_count = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit quiet = 1'b0;

   directed_row_type directed_rows [0:21] = '{
      '{itoaf_pkg::KIND_SDEC, 32'h0000_0000, 1'b1, "0"},
      '{itoaf_pkg::KIND_UDEC, 32'h0000_0000, 1'b1, "0"},
      '{itoaf_pkg::KIND_BIN,  32'h0000_0000, 1'b1, "0"},
      '{KIND_UNUSED,          32'h0000_0000, 1'b1, ""},
      '{itoaf_pkg::KIND_SDEC, 32'h0000_0001, 1'b1, "1"},
      '{itoaf_pkg::KIND_SDEC, 32'hFFFF_FFFF, 1'b1, "-1"},
      '{itoaf_pkg::KIND_SDEC, 32'h7FFF_FFFF, 1'b1, "2147483647"},
      '{itoaf_pkg::KIND_SDEC, 32'h8000_0000, 1'b1, "-2147483648"},
      '{itoaf_pkg::KIND_UDEC, 32'hFFFF_FFFF, 1'b1, "4294967295"},
      '{itoaf_pkg::KIND_UDEC, 32'h8000_0000, 1'b1, "2147483648"},
      '{itoaf_pkg::KIND_BIN,  32'hFFFF_FFFF, 1'b1, "11111111111111111111111111111111"},
      '{itoaf_pkg::KIND_BIN,  32'h0000_0001, 1'b1, "1"},
      '{itoaf_pkg::KIND_BIN,  32'h8000_0000, 1'b1, "10000000000000000000000000000000"},
      '{KIND_UNUSED,          32'hFFFF_FFFF, 1'b1, ""},
      '{itoaf_pkg::KIND_UDEC, 32'd9,          1'b0, ""},
      '{itoaf_pkg::KIND_UDEC, 32'd10,         1'b0, ""},
      '{itoaf_pkg::KIND_UDEC, 32'd999999999,  1'b0, ""},
      '{itoaf_pkg::KIND_UDEC, 32'd1000000000, 1'b0, ""},
      '{itoaf_pkg::KIND_SDEC, 32'hFFFF_FFF6,  1'b0, ""},
      '{itoaf_pkg::KIND_BIN,  32'h0000_0002,  1'b0, ""},
      '{itoaf_pkg::KIND_BIN,  32'h5555_5555,  1'b0, ""},
      '{itoaf_pkg::KIND_SDEC, 32'd12345678,   1'b0, ""}
   };

   integer_to_ascii_formatter_unit #(
      .WORD_BITS(WORD_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ch(rsp_ch),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void queue_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_text.push_back('{ch: text[i], last: (i == text.len() - 1)});
      end
   endfunction

   function automatic void predict_text(input logic [1:0] kind,
                                        input logic [WORD_BITS-1:0] value);
      logic [WORD_BITS-1:0] magnitude;
      logic [WORD_BITS-1:0] radix;
      logic [7:0]           digit;
      string                text;
      if (kind == KIND_UNUSED) begin
         return;
      end
      text = "";
      magnitude = value;
      radix = (kind == itoaf_pkg::KIND_BIN) ? 2 : 10;
      if (kind == itoaf_pkg::KIND_SDEC && value[WORD_BITS-1]) begin
         magnitude = -value;
      end
      do begin
         digit = itoaf_pkg::CHAR_ZERO + 8'(magnitude % radix);
         text = $sformatf("%c%s", digit, text);
         magnitude = magnitude / radix;
      end while (magnitude != 0);
      if (kind == itoaf_pkg::KIND_SDEC && value[WORD_BITS-1]) begin
         text = $sformatf("%c%s", itoaf_pkg::CHAR_MINUS, text);
      end
      queue_text(text);
   endfunction

   function automatic void check_char();
      text_char_type wanted;
      if (pending_text.size() == 0) begin
         $display("%0t: unexpected character %h last %b", $time, rsp_ch, rsp_last);
         errors++;
         return;
      end
      wanted = pending_text.pop_front();
      if (rsp_ch !== wanted.ch) begin
         $display("%0t: ch expected %h got %h", $time, wanted.ch, rsp_ch);
         errors++;
      end
      if (rsp_last !== wanted.last) begin
         $display("%0t: last expected %b got %b", $time, wanted.last, rsp_last);
         errors++;
      end
   endfunction

   task automatic offer_item(input logic [1:0] kind, input logic [WORD_BITS-1:0] value,
                             input bit typed, input string text);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (typed) begin
         queue_text(text);
      end else begin
         predict_text(kind, value);
      end
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // The receiver idles in bursts, and once holds off long enough for the block to back up.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         check_char();
         chars_seen++;
      end
      if (!hold_done && chars_seen >= HOLD_AFTER_CHARS) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [1:0]           kind;
      logic [WORD_BITS-1:0] value;
      int                   items_done;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].kind, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].text);
      end

      items_done = 0;
      while (items_done < RANDOM_ITEMS) begin
         kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 4))
            0: value = $urandom();
            1: value = $urandom_range(0, 20);
            2: begin
               value = 1;
               repeat ($urandom_range(0, 9)) value = value * 10;
               value = value + $urandom_range(0, 2) - 1;
            end
            3: value = $urandom() >> $urandom_range(0, 31);
            default: value = -(WORD_BITS'($urandom_range(1, 1000)));
         endcase
         if (items_done == QUIET_FROM) begin
            quiet = 1'b1;
         end
         offer_item(kind, value, 1'b0, "");
         if (kind != KIND_UNUSED) begin
            items_done++;
         end
      end
      req_valid <= 1'b0;

      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
